@@ sv/dad_pkg.sv @@
// Shared types, codes and calendar helpers for the date adder.
// No dependencies; imported by date_add_days.
`default_nettype none

package dad_pkg;

    // Default field widths
    localparam int DAY_COUNT_BITS_DEF = 16;
    localparam int YEAR_BITS_DEF      = 14;

    localparam int DAY_BITS    = 5;
    localparam int MONTH_BITS  = 4;
    localparam int STATUS_BITS = 2;
    localparam int Y400_BITS   = 9;

    // Gregorian constants
    localparam int CYCLE_DAYS  = 146097;
    localparam int CYCLE_YEARS = 400;

    typedef logic [STATUS_BITS-1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_INVALID = 2'd1;
    localparam status_t STATUS_WRAP    = 2'd2;

    typedef logic [MONTH_BITS-1:0] month_t;
    localparam month_t MONTH_JAN = 4'd1;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_APR = 4'd4;
    localparam month_t MONTH_JUN = 4'd6;
    localparam month_t MONTH_SEP = 4'd9;
    localparam month_t MONTH_NOV = 4'd11;
    localparam month_t MONTH_DEC = 4'd12;

    typedef logic [DAY_BITS-1:0]  day_t;
    typedef logic [Y400_BITS-1:0] y400_t;

    // Leap test from year mod 400 and the two low bits of the year
    function automatic logic is_leap(input y400_t y400, input logic [1:0] ylow);
        logic century;
        begin
            century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
            return (y400 == 9'd0) || ((ylow == 2'b00) && !century);
        end
    endfunction

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        begin
            if (m == MONTH_FEB)
            begin
                len = leap ? 5'd29 : 5'd28;
            end
            else if ((m == MONTH_APR) || (m == MONTH_JUN) ||
                     (m == MONTH_SEP) || (m == MONTH_NOV))
            begin
                len = 5'd30;
            end
            else
            begin
                len = 5'd31;
            end
            return len;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/date_add_days.sv @@
// Gregorian date plus day count: sequencer and month-stepping datapath.
// Depends on dad_pkg (codes, month length, leap test).
//
// Usage:
//   Input stream s_*: one word carries a starting date and a day count.
//   Output stream m_*: one word per input word with the resulting date and
//   a status code (ok, invalid input date, year wrapped past its maximum).
//   An invalid month or day echoes the input date with status invalid.
//   Sequence: YEAR_BITS-7 shift-subtract steps reduce the start year modulo
//   400 (one shift-subtract per cycle), a check state validates the date,
//   then the shared month stepper crosses one month per step (or skips a
//   whole 400-year span while no year wrap lies inside), a last step adds
//   the final partial month, and the output register is loaded.
//   One word is processed at a time: s_tready is high only while the
//   sequencer is idle, but a finished result waiting in the output register
//   does not keep the next word out.
//   If the receiver stalls, the result holds in the output register and the
//   sequencer waits with the next result until that register is taken.
//   Reset (rst_n low, asynchronous) drops any word in flight and clears
//   m_tvalid; the block comes up idle and ready.
`default_nettype none

module date_add_days #(
    parameter int DAY_COUNT_BITS = dad_pkg::DAY_COUNT_BITS_DEF,
    parameter int YEAR_BITS      = dad_pkg::YEAR_BITS_DEF,
    parameter int IN_W  = ((9 + YEAR_BITS + DAY_COUNT_BITS + 7) / 8) * 8,
    parameter int OUT_W = ((11 + YEAR_BITS + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // start_day, start_month, start_year, days_to_add (lowest bit up)
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // end_day, end_month, end_year, status (lowest bit up)
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready
);
    import dad_pkg::*;

    localparam int MOD_STEPS = YEAR_BITS - 7;
    localparam int KW        = $clog2(MOD_STEPS);
    localparam int DW        = (DAY_COUNT_BITS > 18) ? DAY_COUNT_BITS : 18;
    localparam int YB        = YEAR_BITS;
    localparam int DCB       = DAY_COUNT_BITS;

    localparam logic [YB-1:0] YEAR_MAX      = YB'((1 << YB) - 1);
    localparam logic [YB-1:0] YEAR_SKIP_MAX = YB'((1 << YB) - 1 - CYCLE_YEARS);
    localparam logic [DW-1:0] CYCLE_DAYS_W  = DW'(CYCLE_DAYS);
    localparam logic [YB:0]   MOD_BASE      = (YB+1)'(CYCLE_YEARS);
    localparam y400_t         Y400_LAST     = y400_t'(CYCLE_YEARS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t             state_reg,  state_next;
    day_t               day_reg,    day_next;
    month_t             month_reg,  month_next;
    logic [YB-1:0]      year_reg,   year_next;
    logic [DCB-1:0]     days_reg,   days_next;
    logic [YB-1:0]      rem_reg,    rem_next;
    logic [KW-1:0]      k_reg,      k_next;
    y400_t              y400_reg,   y400_next;
    status_t            status_reg, status_next;
    logic [OUT_W-1:0]   out_data_reg,  out_data_next;
    logic               out_valid_reg, out_valid_next;

    // Shared datapath terms
    logic               leap;
    day_t               mlen;
    day_t               rem_days;
    logic [YB:0]        mod_sub;
    logic [DW-1:0]      days_ext;
    logic               skip;
    logic               date_ok;

    assign leap     = is_leap(y400_reg, year_reg[1:0]);
    assign mlen     = month_len(month_reg, leap);
    assign rem_days = mlen - day_reg;
    assign mod_sub  = MOD_BASE << k_reg;
    assign days_ext = DW'(days_reg);
    assign skip     = (days_ext >= CYCLE_DAYS_W) && (year_reg <= YEAR_SKIP_MAX);
    assign date_ok  = (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC) &&
                      (day_reg != 5'd0) && (day_reg <= mlen);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        days_next      = days_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        y400_next      = y400_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        // Drop the output word once the receiver takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    day_next    = s_tdata[4:0];
                    month_next  = s_tdata[8:5];
                    year_next   = s_tdata[9 +: YB];
                    days_next   = s_tdata[9 + YB +: DCB];
                    rem_next    = s_tdata[9 +: YB];
                    k_next      = KW'(MOD_STEPS - 1);
                    status_next = STATUS_OK;
                    state_next  = ST_MOD;
                end
            end

            ST_MOD:
            begin
                // One restoring step of year mod 400
                if ({1'b0, rem_reg} >= mod_sub)
                begin
                    rem_next = rem_reg - mod_sub[YB-1:0];
                end
                if (k_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end

            ST_CHECK:
            begin
                // rem_reg is now below 400; leap and mlen follow it
                if (!date_ok)
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (days_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (skip)
                begin
                    // A 400-year span is exactly CYCLE_DAYS days
                    year_next = year_reg + YB'(CYCLE_YEARS);
                    days_next = DCB'(days_ext - CYCLE_DAYS_W);
                end
                else if (days_reg <= DCB'(rem_days))
                begin
                    day_next   = day_reg + days_reg[4:0];
                    days_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    days_next = days_reg - (DCB'(rem_days) + DCB'(1));
                    day_next  = 5'd1;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        if (year_reg == YEAR_MAX)
                        begin
                            year_next   = '0;
                            y400_next   = '0;
                            status_next = STATUS_WRAP;
                        end
                        else
                        begin
                            year_next = year_reg + 1'b1;
                            y400_next = (y400_reg == Y400_LAST) ? '0 : y400_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                // Load the output register once it is free or being taken
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = OUT_W'({status_reg, year_reg, month_reg, day_reg});
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Year mod 400 comes out of the reduction on its last step
        if ((state_reg == ST_MOD) && (k_reg == '0))
        begin
            y400_next = y400_t'(rem_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            days_reg      <= '0;
            rem_reg       <= '0;
            k_reg         <= '0;
            y400_reg      <= '0;
            status_reg    <= STATUS_OK;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            days_reg      <= days_next;
            rem_reg       <= rem_next;
            k_reg         <= k_next;
            y400_reg      <= y400_next;
            status_reg    <= status_next;
            out_data_reg  <= out_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
